>>> rtl/dvrf_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dvrf_pkg
// Shared types and constants for the deletion vector row filter: store
// geometry, word formats of both channels, operation and status codes.
// -----------------------------------------------------------------------------
package dvrf_pkg;

   // Store and batch geometry.
   localparam int MAX_DELETES   = 4096;
   localparam int BATCH_ROWS    = 64;
   localparam int POSITION_BITS = 48;

   // Derived widths.
   localparam int ADDR_BITS  = $clog2(MAX_DELETES);
   localparam int LEVEL_BITS = $clog2(MAX_DELETES + 1);
   localparam int OFF_BITS   = (BATCH_ROWS > 1) ? $clog2(BATCH_ROWS) : 1;

   // Fixed field widths of the channels.
   localparam int OP_BITS     = 2;
   localparam int COUNT_BITS  = 7;
   localparam int MASK_BITS   = 64;
   localparam int STATUS_BITS = 2;

   // Operation codes.
   typedef enum logic [OP_BITS-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_FILTER = 2'd2
   } op_type;

   // Status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_ORDER = 2'd2
   } status_type;

   // Request word.
   typedef struct packed {
      logic [OP_BITS-1:0]       op;
      logic [POSITION_BITS-1:0] position;
      logic [COUNT_BITS-1:0]    batch_count;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [MASK_BITS-1:0]   keep_mask;
      logic [COUNT_BITS-1:0]  kept_count;
      logic [STATUS_BITS-1:0] status;
   } rsp_type;

   // Read request from the filter engine to the store.
   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
   } mem_rd_type;

endpackage

>>> rtl/dvrf_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dvrf_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read word.
// -----------------------------------------------------------------------------
module dvrf_ram #(
   parameter int ADDR_BITS = 12,
   parameter int DATA_BITS = 48
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered output.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/dvrf_filter.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dvrf_filter
// Filter engine: binary search for the first stored deletion at or after the
// batch start, then a streaming walk over the deletions inside the batch.
// -----------------------------------------------------------------------------
module dvrf_filter import dvrf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  req_type                  cmd,
   input  logic [LEVEL_BITS-1:0]    fill_level,
   output mem_rd_type               mem_rd,
   input  logic [POSITION_BITS-1:0] rd_data,
   output logic                     busy,
   output logic                     res_valid,
   output rsp_type                  res
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_WALK
   } state_type;

   state_type                state_ff, state_in;
   logic [POSITION_BITS-1:0] key_ff, key_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [LEVEL_BITS-1:0]    lo_ff, lo_in;
   logic [LEVEL_BITS-1:0]    hi_ff, hi_in;
   logic [LEVEL_BITS-1:0]    mid_ff, mid_in;
   logic [LEVEL_BITS-1:0]    ptr_ff, ptr_in;
   logic                     pend_ff, pend_in;
   logic [MASK_BITS-1:0]     mask_ff, mask_in;
   logic [COUNT_BITS-1:0]    kept_ff, kept_in;
   logic                     valid_ff, valid_in;

   logic [COUNT_BITS-1:0]    sat_count;
   logic [LEVEL_BITS:0]      mid_sum;
   logic [LEVEL_BITS-1:0]    mid;
   logic [POSITION_BITS-1:0] offset;
   logic                     in_range;
   logic                     more;

   // Batch count saturates at the batch width.
   assign sat_count = (cmd.batch_count > COUNT_BITS'(BATCH_ROWS)) ?
                      COUNT_BITS'(BATCH_ROWS) : cmd.batch_count;

   // Midpoint of the half-open search interval.
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[LEVEL_BITS:1];

   // A deletion belongs to the batch when its distance from the start is
   // below the count; the search guarantees it is not below the start.
   assign offset   = rd_data - key_ff;
   assign in_range = offset < POSITION_BITS'(count_ff);
   assign more     = ptr_ff < fill_level;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      count_in = count_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      ptr_in   = ptr_ff;
      pend_in  = 1'b0;
      mask_in  = mask_ff;
      kept_in  = kept_ff;
      valid_in = 1'b0;
      mem_rd   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in   = cmd.position;
               count_in = sat_count;
               mask_in  = MASK_BITS'(~({BATCH_ROWS{1'b1}} << sat_count));
               kept_in  = sat_count;
               lo_in    = '0;
               hi_in    = fill_level;
               if (sat_count == '0) begin
                  valid_in = 1'b1;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mem_rd.en   = 1'b1;
               mem_rd.addr = mid[ADDR_BITS-1:0];
               mid_in      = mid;
               state_in    = ST_COMPARE;
            end else begin
               ptr_in   = lo_ff;
               state_in = ST_WALK;
            end
         end
         ST_COMPARE: begin
            if (rd_data < key_ff) begin
               lo_in = mid_ff + LEVEL_BITS'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_SEARCH;
         end
         ST_WALK: begin
            // Check the word read last cycle while the next read goes out.
            if (pend_ff && in_range) begin
               mask_in = mask_ff & ~(MASK_BITS'(1) << offset[OFF_BITS-1:0]);
               kept_in = kept_ff - COUNT_BITS'(1);
            end
            if ((pend_ff && !in_range) || (!pend_ff && !more)) begin
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else if (more) begin
               mem_rd.en   = 1'b1;
               mem_rd.addr = ptr_ff[ADDR_BITS-1:0];
               ptr_in      = ptr_ff + LEVEL_BITS'(1);
               pend_in     = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      count_ff <= count_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      ptr_ff   <= ptr_in;
      mask_ff  <= mask_in;
      kept_ff  <= kept_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign res_valid      = valid_ff;
   assign res.keep_mask  = mask_ff;
   assign res.kept_count = kept_ff;
   assign res.status     = STATUS_OK;

endmodule

>>> rtl/deletion_vector_row_filter.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// deletion_vector_row_filter
// Keeps a sorted store of deleted row positions and filters row batches
// against it.
// -----------------------------------------------------------------------------
// Usage:
//   A command word on req_item is taken when start is high and busy is low.
//   Each command gives exactly one response word on rsp_item, marked by a
//   single-cycle rsp_strobe; the receiver cannot stall it.
//   Clear and append answer in the cycle after acceptance, and busy stays low,
//   so these commands can be issued every cycle.
//   A filter with a nonzero count raises busy for its whole run. The store of
//   up to 4096 entries sits in one RAM with a registered read: each halving of
//   the binary search passes through a search state and a compare state, and
//   the walk streams one deletion per cycle. The response appears in the cycle
//   busy falls. A zero count answers in the cycle after acceptance and leaves
//   busy low.
//   Reset clears the fill level and the last appended position; the store
//   needs no clearing pass because reads stay below the fill level.
// -----------------------------------------------------------------------------
module deletion_vector_row_filter import dvrf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   logic [LEVEL_BITS-1:0]    fill_ff, fill_in;
   logic [POSITION_BITS-1:0] last_ff, last_in;
   logic                     own_valid_ff, own_valid_in;
   status_type               own_status_ff, own_status_in;

   logic                     accept;
   logic                     filt_start;
   logic                     wr_en;
   mem_rd_type               mem_rd;
   logic [POSITION_BITS-1:0] rd_data;
   logic                     filt_busy;
   logic                     filt_valid;
   rsp_type                  filt_rsp;
   op_type                   op;

   assign op         = op_type'(req_item.op);
   assign accept     = start && !busy;
   assign filt_start = accept && (op == OP_FILTER);

   // Clear, append and spare op codes are handled here in the cycle of acceptance.
   always_comb begin
      fill_in       = fill_ff;
      last_in       = last_ff;
      own_valid_in  = 1'b0;
      own_status_in = STATUS_OK;
      wr_en         = 1'b0;
      if (accept) begin
         case (op)
            OP_CLEAR: begin
               fill_in      = '0;
               last_in      = '0;
               own_valid_in = 1'b1;
            end
            OP_APPEND: begin
               own_valid_in = 1'b1;
               if (fill_ff == LEVEL_BITS'(MAX_DELETES)) begin
                  own_status_in = STATUS_FULL;
               end else if ((fill_ff != '0) && (req_item.position <= last_ff)) begin
                  own_status_in = STATUS_ORDER;
               end else begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + LEVEL_BITS'(1);
                  last_in = req_item.position;
               end
            end
            OP_FILTER: begin
               own_valid_in = 1'b0;
            end
            default: begin
               own_valid_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         last_ff      <= '0;
         own_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         last_ff      <= last_in;
         own_valid_ff <= own_valid_in;
      end
      own_status_ff <= own_status_in;
   end

   // Deleted position store.
   dvrf_ram #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (POSITION_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[ADDR_BITS-1:0]),
      .wr_data (req_item.position),
      .rd_en   (mem_rd.en),
      .rd_addr (mem_rd.addr),
      .rd_data (rd_data)
   );

   // Search and walk engine.
   dvrf_filter u_filter (
      .clock      (clock),
      .reset      (reset),
      .start      (filt_start),
      .cmd        (req_item),
      .fill_level (fill_ff),
      .mem_rd     (mem_rd),
      .rd_data    (rd_data),
      .busy       (filt_busy),
      .res_valid  (filt_valid),
      .res        (filt_rsp)
   );

   // The two response sources never fire in the same cycle.
   assign busy       = filt_busy;
   assign rsp_strobe = filt_valid || own_valid_ff;
   always_comb begin
      if (filt_valid) begin
         rsp_item = filt_rsp;
      end else begin
         rsp_item.keep_mask  = '0;
         rsp_item.kept_count = '0;
         rsp_item.status     = own_status_ff;
      end
   end

endmodule

>>> rtl/dvrf_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dvrf_checker
// Port-level checks of the row filter's command and response behavior.
// -----------------------------------------------------------------------------
module dvrf_checker import dvrf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // A filter word with a nonzero count holds the block busy in the following
   // cycle.
   a_filter_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.op == OP_FILTER) && (req_item.batch_count != '0)
      |=> busy)
      else $error("filter word did not raise busy");

   // Any word other than a filter is answered in the next cycle.
   a_short_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.op != OP_FILTER) |=> rsp_strobe && !busy)
      else $error("short command not answered in one cycle");

   // The end of a filter run shows its word.
   a_filter_answer: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("filter finished without a response");

   // The survivor count agrees with the mask.
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($countones(rsp_item.keep_mask) == int'(rsp_item.kept_count)))
      else $error("kept count disagrees with keep mask");

   // A refused append carries no mask.
   a_refusal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.status != STATUS_OK) |->
         (rsp_item.keep_mask == '0) && (rsp_item.kept_count == '0))
      else $error("refused append carries a mask");

endmodule

bind deletion_vector_row_filter dvrf_checker u_dvrf_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for deletion_vector_row_filter. Command words go in over
// the start/busy handshake with random gaps. A ledger class keeps its own
// sorted copy of the deletion store, predicts the response word of every
// accepted command and checks each strobed response against the oldest
// prediction. The directed part covers the field extremes and the refusal
// cases, and a second phase fills the store to capacity. After that come
// random episodes of ascending appends and filter batches, mixed with clears,
// noise and spare op codes.
// -----------------------------------------------------------------------------
import dvrf_pkg::*;

// Predicts and checks the response words of the row filter.
class survivor_ledger;
   logic [POSITION_BITS-1:0] store_copy [MAX_DELETES];
   int unsigned              fill = 0;
   logic [POSITION_BITS-1:0] last_pos = '0;
   rsp_type                  expected_words [$];
   int unsigned              errors = 0;
   int unsigned              checked = 0;

   // Works out the response word of one command and updates the store copy.
   function rsp_type predict_word(req_type r);
      rsp_type                  w;
      int unsigned              lo;
      int unsigned              hi;
      int unsigned              mid;
      int unsigned              count;
      logic [POSITION_BITS-1:0] off;
      logic [MASK_BITS-1:0]     mask;
      int unsigned              kept;
      w = '0;
      case (r.op)
         OP_CLEAR: begin
            fill = 0;
            last_pos = '0;
         end
         OP_APPEND: begin
            if (fill >= MAX_DELETES) begin
               w.status = STATUS_FULL;
            end else if (fill > 0 && r.position <= last_pos) begin
               w.status = STATUS_ORDER;
            end else begin
               store_copy[fill] = r.position;
               fill++;
               last_pos = r.position;
            end
         end
         OP_FILTER: begin
            count = (r.batch_count > BATCH_ROWS) ? BATCH_ROWS : r.batch_count;
            if (count != 0) begin
               mask = {MASK_BITS{1'b1}} >> (MASK_BITS - count);
               kept = count;
               // Lower bound: first stored deletion not below the batch start.
               lo = 0;
               hi = fill;
               while (lo < hi) begin
                  mid = (lo + hi) / 2;
                  if (store_copy[mid] < r.position) begin
                     lo = mid + 1;
                  end else begin
                     hi = mid;
                  end
               end
               // Strike out every deletion that lands inside the batch.
               while (lo < fill) begin
                  off = store_copy[lo] - r.position;
                  if (off >= count) break;
                  mask[off[5:0]] = 1'b0;
                  kept--;
                  lo++;
               end
               w.keep_mask = mask;
               w.kept_count = kept[COUNT_BITS-1:0];
            end
         end
         default: begin
         end
      endcase
      return w;
   endfunction

   // Records an accepted command word.
   function void note_command(req_type r);
      expected_words.push_back(predict_word(r));
   endfunction

   task report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   // Compares one response word with the oldest prediction.
   task check_word(input rsp_type got);
      rsp_type want;
      if (expected_words.size() == 0) begin
         report_mismatch($sformatf("response word %h with nothing outstanding", got));
      end else begin
         want = expected_words.pop_front();
         if (got.keep_mask !== want.keep_mask)
            report_mismatch($sformatf("word %0d keep_mask %h, expected %h",
                                      checked, got.keep_mask, want.keep_mask));
         if (got.kept_count !== want.kept_count)
            report_mismatch($sformatf("word %0d kept_count %0d, expected %0d",
                                      checked, got.kept_count, want.kept_count));
         if (got.status !== want.status)
            report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                      checked, got.status, want.status));
      end
      checked++;
   endtask
endclass

module testbench;

   localparam logic [OP_BITS-1:0]       OP_SPARE = 2'd3;
   localparam logic [POSITION_BITS-1:0] TOP_POS  = {POSITION_BITS{1'b1}};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   survivor_ledger book;
   bit             calm;
   int unsigned    sent_by_op [4];
   int unsigned    random_sent;

   deletion_vector_row_filter dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #5 clock = ~clock;

   // Response monitor: every strobed word is checked at the closing edge.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) book.check_word(rsp_item);
   end

   // Sends one command word after a random gap and waits for acceptance.
   task issue(input logic [OP_BITS-1:0] op, input logic [POSITION_BITS-1:0] pos,
              input logic [COUNT_BITS-1:0] cnt);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item.op = op;
      req_item.position = pos;
      req_item.batch_count = cnt;
      start = 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      book.note_command(req_item);
      sent_by_op[op]++;
      @(negedge clock);
   endtask

   // Picks a batch start near a stored deletion, or anywhere.
   function logic [POSITION_BITS-1:0] pick_start();
      int unsigned idx;
      if (book.fill > 0 && $urandom_range(0, 3) != 0) begin
         idx = $urandom_range(0, book.fill - 1);
         return book.store_copy[idx] - $urandom_range(0, 70);
      end
      return POSITION_BITS'({$urandom, $urandom});
   endfunction

   function logic [COUNT_BITS-1:0] pick_count();
      if ($urandom_range(0, 7) == 0) return COUNT_BITS'($urandom_range(0, 127));
      return COUNT_BITS'($urandom_range(1, BATCH_ROWS));
   endfunction

   // Random episode: optional clear, a run of appends, filter batches, then an optional spare op word.
   task run_episode();
      int                       n;
      int                       k;
      int                       r;
      logic [POSITION_BITS-1:0] tail;
      logic [POSITION_BITS-1:0] pos;
      calm = ($urandom_range(0, 3) == 0);
      tail = POSITION_BITS'({$urandom, $urandom} >> $urandom_range(0, 40));
      if ($urandom_range(0, 7) == 0) begin
         issue(OP_CLEAR, POSITION_BITS'({$urandom, $urandom}), COUNT_BITS'($urandom));
         random_sent++;
         if ($urandom_range(0, 2) == 0) tail = TOP_POS - $urandom_range(0, 3000);
      end
      n = $urandom_range(0, 24);
      for (k = 0; k < n; k++) begin
         if (book.fill > 0) tail = book.last_pos;
         r = $urandom_range(0, 9);
         if ($urandom_range(0, 11) == 0) begin
            // Noise: a wild position or one at or below the last append.
            pos = ($urandom_range(0, 1) == 0) ? POSITION_BITS'({$urandom, $urandom}) :
                  tail - $urandom_range(0, 3);
         end else if (book.fill == 0) begin
            pos = tail;
         end else if (r < 5) begin
            pos = tail + 1;
         end else if (r < 9) begin
            pos = tail + $urandom_range(2, 4);
         end else begin
            pos = tail + $urandom_range(5, 300);
         end
         issue(OP_APPEND, pos, COUNT_BITS'($urandom));
         random_sent++;
      end
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) begin
         issue(OP_FILTER, pick_start(), pick_count());
         random_sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
         issue(OP_SPARE, POSITION_BITS'({$urandom, $urandom}), COUNT_BITS'($urandom));
         random_sent++;
      end
   endtask

   // Main sequence.
   initial begin
      logic [POSITION_BITS-1:0] pos;
      int                       i;
      book = new();
      calm = 1'b0;
      random_sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty store, order refusals, saturation, zero count.
      issue(OP_FILTER, '0, 7'd64);
      issue(OP_APPEND, '0, '0);
      issue(OP_APPEND, '0, '0);
      issue(OP_APPEND, 48'd5, 7'd127);
      issue(OP_APPEND, 48'd3, '0);
      issue(OP_APPEND, 48'd63, '0);
      issue(OP_APPEND, 48'd64, '0);
      issue(OP_FILTER, '0, 7'd64);
      issue(OP_FILTER, '0, '0);
      issue(OP_FILTER, 48'd1, 7'd127);
      issue(OP_FILTER, 48'd60, 7'd10);
      issue(OP_SPARE, TOP_POS, 7'd127);
      issue(OP_FILTER, 48'd5, 7'd1);
      issue(OP_CLEAR, TOP_POS, 7'd127);
      // Top of the position space: no row sum may wrap.
      issue(OP_APPEND, TOP_POS - 1, '0);
      issue(OP_APPEND, TOP_POS, '0);
      issue(OP_APPEND, TOP_POS, '0);
      issue(OP_FILTER, TOP_POS - 63, 7'd64);
      issue(OP_FILTER, TOP_POS, 7'd64);
      issue(OP_FILTER, TOP_POS - 1, 7'd1);
      // An empty store takes any position, zero included.
      issue(OP_CLEAR, '0, '0);
      issue(OP_APPEND, '0, '0);
      issue(OP_FILTER, '0, 7'd2);

      // Fill the store to capacity, probe it, then try to overflow it.
      issue(OP_CLEAR, '0, '0);
      pos = POSITION_BITS'($urandom);
      for (i = 0; i < MAX_DELETES; i++) begin
         calm = ((i % 512) < 256);
         pos = pos + (($urandom_range(0, 2) == 0) ? $urandom_range(2, 3) : 1);
         issue(OP_APPEND, pos, '0);
      end
      calm = 1'b0;
      issue(OP_FILTER, book.store_copy[0], 7'd64);
      issue(OP_FILTER, book.store_copy[MAX_DELETES-1] - 40, 7'd64);
      issue(OP_FILTER, book.store_copy[MAX_DELETES-1] + 1, 7'd64);
      for (i = 0; i < 6; i++) issue(OP_FILTER, pick_start(), pick_count());
      issue(OP_APPEND, pos + 1, '0);
      issue(OP_APPEND, '0, '0);
      issue(OP_CLEAR, '0, '0);

      // Random episodes.
      while (random_sent < 600) run_episode();

      // Drain the outstanding responses, then wait before the summary.
      start = 1'b0;
      while (book.expected_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Run covered %0d clears, %0d appends, %0d filters, %0d spare-op words.",
               sent_by_op[OP_CLEAR], sent_by_op[OP_APPEND], sent_by_op[OP_FILTER],
               sent_by_op[OP_SPARE]);
      $display("It filled the store to capacity once and checked %0d response words.",
               book.checked);
      if (book.errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake or a lost response.
   initial begin
      #50_000_000;
      $display("Timeout with %0d response words outstanding.", book.expected_words.size());
      $display("testbench failed");
      $finish;
   end

endmodule

>>> deletion_vector_row_filter.f
rtl/dvrf_pkg.sv
rtl/dvrf_ram.sv
rtl/dvrf_filter.sv
rtl/deletion_vector_row_filter.sv
rtl/dvrf_checker.sv
bench/testbench.sv
